// ===== rtl/core/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int ADDR_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CMP_W     = 34;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_OOM     = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 8'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              free;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_entry data;
    } t_tbl_wr;

    typedef struct packed {
        logic ge;
        logic eq;
    } t_cmp;

    typedef struct packed {
        logic              base_wr;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        status;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/core/ffba_if.sv =====
// ----------------------------------------------------------------------------
// ffba_if
// Request, result and configuration channels of the block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] size;
    logic [31:0] address;

    modport source (output valid, output req_type, output size, output address,
                    input ready);
    modport sink   (input valid, input req_type, input size, input address,
                    output ready);
endinterface

interface ffba_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] address_res;
    logic [1:0]  status;

    modport source (output valid, output address_res, output status, input ready);
    modport sink   (input valid, input address_res, input status, output ready);
endinterface

interface ffba_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ffba_table.sv =====
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_table
    import ffba_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire t_tbl_wr          i_wr,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_entry                o_rdata
);

    t_entry r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.data;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ffba_cmp.sv =====
// ----------------------------------------------------------------------------
// ffba_cmp
// Shared magnitude and equality comparator used by every scan step.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_cmp
    import ffba_pkg::*;
(
    input  wire logic [CMP_W-1:0] i_a,
    input  wire logic [CMP_W-1:0] i_b,
    output t_cmp                  o_cmp
);

    logic [CMP_W:0] w_diff;

    // borrow out of a - b clear means a >= b
    assign w_diff   = {1'b0, i_a} - {1'b0, i_b};
    assign o_cmp.ge = ~w_diff[CMP_W];
    assign o_cmp.eq = (w_diff[CMP_W-1:0] == '0);

endmodule

`default_nettype wire

// ===== rtl/core/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: walks the block table one entry a cycle through the
// shared comparator, then updates the table, block count and heap top.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_req_type,
    input  wire logic [ADDR_W-1:0] i_size,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_take,
    output logic                   o_ready,
    output logic                   o_done,
    output t_res                   o_res,
    output t_tbl_wr                o_wr,
    output logic [IDX_W-1:0]       o_waddr,
    output logic [IDX_W-1:0]       o_raddr,
    input  wire t_entry            i_rdata,
    output logic [CMP_W-1:0]       o_cmp_a,
    output logic [CMP_W-1:0]       o_cmp_b,
    input  wire t_cmp              i_cmp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [CMP_W-1:0]  HDR_W   = CMP_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] HDR_A   = ADDR_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0]  CNT_ONE = CNT_W'(1);

    logic [1:0]        r_state, n_state;
    logic              r_kind, n_kind;
    logic [ADDR_W-1:0] r_size, n_size;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CMP_W-1:0]  r_end, n_end;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_chk, n_chk;
    logic [IDX_W-1:0]  r_chk_idx, n_chk_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_top, n_top;
    t_res              r_res, n_res;

    logic w_issue;
    logic w_hit;

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_FIN);
    assign o_res   = r_res;
    assign w_issue = (r_idx < r_count);

    // comparator operands: table entry while checking, append bound otherwise
    always_comb begin
        if (r_chk) begin
            if (r_kind == REQ_ALLOC) begin
                o_cmp_a = {2'b00, i_rdata.size};
                o_cmp_b = {2'b00, r_size};
            end else begin
                o_cmp_a = {2'b00, i_rdata.start} + HDR_W;
                o_cmp_b = {2'b00, r_addr};
            end
        end else begin
            o_cmp_a = {2'b00, i_cfg.limit};
            o_cmp_b = r_end;
        end
    end

    assign w_hit = r_chk && ((r_kind == REQ_ALLOC) ? (i_rdata.free && i_cmp.ge) : i_cmp.eq);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_size    = r_size;
        n_addr    = r_addr;
        n_end     = r_end;
        n_idx     = r_idx;
        n_chk     = 1'b0;
        n_chk_idx = r_chk_idx;
        n_count   = r_count;
        n_top     = r_top;
        n_res     = r_res;
        o_wr      = '0;
        o_waddr   = r_chk_idx;
        o_raddr   = r_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind = i_req_type;
                    n_size = i_size;
                    n_addr = i_address;
                    n_end  = {2'b00, r_top} + HDR_W + {2'b00, i_size};
                    n_idx  = '0;
                    if ((i_req_type == REQ_ALLOC && i_size == '0) ||
                        (i_req_type == REQ_FREE && i_address == '0)) begin
                        n_res   = '{addr: '0, status: ST_NULL};
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    // first match wins; drop the read still in flight
                    if (r_kind == REQ_ALLOC) begin
                        o_wr.we         = 1'b1;
                        o_wr.data       = i_rdata;
                        o_wr.data.free  = 1'b0;
                        n_res = '{addr: i_rdata.start + HDR_A, status: ST_OK};
                    end else begin
                        if (CNT_W'(r_chk_idx) + CNT_ONE == r_count) begin
                            n_top   = i_rdata.start;
                            n_count = CNT_W'(r_chk_idx);
                        end else begin
                            o_wr.we        = 1'b1;
                            o_wr.data      = i_rdata;
                            o_wr.data.free = 1'b1;
                        end
                        n_res = '{addr: '0, status: ST_OK};
                    end
                    n_state = S_FIN;
                end else if (w_issue) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_ONE;
                end else if (!r_chk) begin
                    // table walked without a match
                    if (r_kind == REQ_FREE) begin
                        n_res = '{addr: '0, status: ST_UNKNOWN};
                    end else if (r_count == CNT_MAX || !i_cmp.ge) begin
                        n_res = '{addr: '0, status: ST_OOM};
                    end else begin
                        o_wr.we        = 1'b1;
                        o_wr.data      = '{start: r_top, size: r_size, free: 1'b0};
                        o_waddr        = r_count[IDX_W-1:0];
                        n_count        = r_count + CNT_ONE;
                        n_top          = r_end[ADDR_W-1:0];
                        n_res = '{addr: r_top + HDR_A, status: ST_OK};
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // base moves the heap top only while the table is empty
        if (i_cfg.base_wr && r_count == '0) begin
            n_top = i_cfg.base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chk   <= 1'b0;
            r_count <= '0;
            r_top   <= 32'd4096;
        end else begin
            r_state <= n_state;
            r_chk   <= n_chk;
            r_count <= n_count;
            r_top   <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_size    <= n_size;
        r_addr    <= n_addr;
        r_end     <= n_end;
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
        r_res     <= n_res;
    end

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap block allocator with a 64-entry block table.
// ----------------------------------------------------------------------------
// Sequence: a null request goes straight to the result; any other request
//   walks the k live entries, one entry a cycle through the table read port,
//   until the first match; when none matches, an allocation appends a block.
// Throughput: one request at a time; the next is taken the cycle after the
//   result enters the output register.
// Reset: synchronous, active low; block count clears, heap top and heap_base
//   return to 4096, heap_limit to 1048576. The table needs no clearing.
`default_nettype none

module first_fit_block_allocator_top
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ffba_req_if.sink   i_req,
    ffba_res_if.source o_res,
    ffba_cfg_if.sink   i_cfg
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic [ADDR_W-1:0] r_heap_base;
    logic [ADDR_W-1:0] r_heap_limit;
    logic              r_out_valid;
    t_res              r_out;

    t_cfg             w_cfg;
    t_res             w_res;
    t_tbl_wr          w_wr;
    t_entry           w_rdata;
    t_cmp             w_cmp;
    logic [IDX_W-1:0] w_waddr;
    logic [IDX_W-1:0] w_raddr;
    logic [CMP_W-1:0] w_cmp_a;
    logic [CMP_W-1:0] w_cmp_b;
    logic             w_ready;
    logic             w_done;
    logic             w_out_free;

    assign i_cfg.ready   = 1'b1;
    assign w_cfg.base_wr = i_cfg.valid && (i_cfg.index == CFG_BASE);
    assign w_cfg.base    = i_cfg.data;
    assign w_cfg.limit   = r_heap_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= 32'd4096;
            r_heap_limit <= 32'd1048576;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BASE:  r_heap_base  <= i_cfg.data;
                CFG_LIMIT: r_heap_limit <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready = w_ready;

    ffba_table #(
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_waddr (w_waddr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ffba_cmp u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_cmp_b),
        .o_cmp (w_cmp)
    );

    ffba_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_req.valid && w_ready),
        .i_req_type (i_req.req_type),
        .i_size     (i_req.size),
        .i_address  (i_req.address),
        .i_cfg      (w_cfg),
        .i_take     (w_out_free),
        .o_ready    (w_ready),
        .o_done     (w_done),
        .o_res      (w_res),
        .o_wr       (w_wr),
        .o_waddr    (w_waddr),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata),
        .o_cmp_a    (w_cmp_a),
        .o_cmp_b    (w_cmp_b),
        .i_cmp      (w_cmp)
    );

    // output register: hold the result until the sink takes it
    assign w_out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_done) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.address_res = r_out.addr;
    assign o_res.status      = r_out.status;

    // heap_base is kept as a readable copy of the last write
    logic w_base_unused;
    assign w_base_unused = ^r_heap_base;

    a_fail_null_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != ST_OK) |-> (o_res.address_res == '0))
        else $error("failed request carries a nonzero address");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while a transaction is in progress");

    a_done_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !i_req.ready)
        else $error("sequencer ready while a result is pending");

    a_base_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.index == CFG_BASE) |=>
            (r_heap_base == $past(i_cfg.data) && w_base_unused == ^$past(i_cfg.data)))
        else $error("heap_base write lost");

endmodule

`default_nettype wire
